// File: src/prs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prs_pkg: shared types and constants of the priority ready scheduler
// Field widths of the item channels, mode and status codes, and the default
// thread count.
// ----------------------------------------------------------------------------
package prs_pkg;

  // Field widths of the item channels.
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned INDEX_W  = 4;
  localparam int unsigned TICKS_W  = 32;
  localparam int unsigned STATUS_W = 2;

  // Default number of threads with a delay counter.
  localparam int unsigned DEFAULT_THREADS = 8;

  // Operation carried by an input item.
  typedef enum logic [MODE_W-1:0] {
    MODE_TICK   = 2'd0,
    MODE_DELAY  = 2'd1,
    MODE_YIELD  = 2'd2,
    MODE_CREATE = 2'd3
  } mode_e;

  // Outcome reported with each result item.
  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_RANGE     = 2'd1,
    STATUS_IS_READY  = 2'd2
  } status_e;

endpackage

// File: src/prs_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prs_in_if: request channel of the priority ready scheduler
// Valid/ready channel that carries one scheduler operation per item.
// ----------------------------------------------------------------------------
interface prs_in_if;
  logic                          valid;
  logic                          ready;
  logic [prs_pkg::MODE_W-1:0]    mode;
  logic [prs_pkg::INDEX_W-1:0]   thread_index;
  logic [prs_pkg::TICKS_W-1:0]   delay_ticks;

  modport source (output valid, output mode, output thread_index, output delay_ticks,
                  input ready);
  modport sink   (input valid, input mode, input thread_index, input delay_ticks,
                  output ready);
endinterface

// File: src/prs_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prs_out_if: result channel of the priority ready scheduler
// Valid/ready channel that carries one scheduling result per item.
// ----------------------------------------------------------------------------
interface prs_out_if;
  logic                          valid;
  logic                          ready;
  logic [prs_pkg::STATUS_W-1:0]  status;
  logic [prs_pkg::INDEX_W-1:0]   running_thread;
  logic [prs_pkg::INDEX_W-1:0]   previous_thread;
  logic                          switch_request;

  modport source (output valid, output status, output running_thread,
                  output previous_thread, output switch_request, input ready);
  modport sink   (input valid, input status, input running_thread,
                  input previous_thread, input switch_request, output ready);
endinterface

// File: src/prs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prs_ram: generic single-write, single-read memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module prs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/prs_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prs_seq: sequencer and shared datapath of the priority ready scheduler
// On a tick, walks the delay counters through one shared decrementer; then
// scans the ready bits one slot a cycle to pick the lowest ready slot.
// ----------------------------------------------------------------------------
module prs_seq #(
  parameter int unsigned THREADS = prs_pkg::DEFAULT_THREADS,
  localparam int unsigned AW     = (THREADS > 1) ? $clog2(THREADS) : 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  prs_in_if.sink                      in_i,
  prs_out_if.source                   out_o,
  output logic                        ram_we_o,
  output logic [AW-1:0]               ram_waddr_o,
  output logic [prs_pkg::TICKS_W-1:0] ram_wdata_o,
  output logic [AW-1:0]               ram_raddr_o,
  input  logic [prs_pkg::TICKS_W-1:0] ram_rdata_i
);
  import prs_pkg::*;

  // Slot numbers run from 0 to THREADS; slot THREADS is the idle slot.
  localparam int unsigned SW = $clog2(THREADS + 1);
  localparam int unsigned XW = (SW > INDEX_W) ? SW : INDEX_W;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_TICK = 4'b0010,
    S_SCAN = 4'b0100,
    S_RESP = 4'b1000
  } state_e;

  state_e               state_q, state_d;
  logic [THREADS:0]     ready_q, ready_d;
  logic [THREADS-1:0]   cvalid_q, cvalid_d;
  logic [SW-1:0]        cur_q, cur_d;
  logic [SW-1:0]        last_q, last_d;
  logic                 sw_q, sw_d;
  logic [STATUS_W-1:0]  status_q, status_d;
  logic [SW-1:0]        ptr_q, ptr_d;
  logic                 pend_q, pend_d;
  logic [AW-1:0]        wptr_q, wptr_d;

  logic                 out_valid_q, out_valid_d;
  logic [STATUS_W-1:0]  out_status_q, out_status_d;
  logic [INDEX_W-1:0]   out_run_q, out_run_d;
  logic [INDEX_W-1:0]   out_prev_q, out_prev_d;
  logic                 out_sw_q, out_sw_d;

  logic                 accept;
  logic                 out_free;
  logic                 rd_issue;
  logic [TICKS_W-1:0]   cnt_cur;
  logic [TICKS_W-1:0]   cnt_dec;
  logic [XW-1:0]        cur_ext;
  logic [XW-1:0]        last_ext;
  logic [SW-1:0]        idx_slot;
  logic [AW-1:0]        idx_addr;
  logic                 idx_bad;

  assign accept   = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;
  assign rd_issue = (ptr_q < SW'(THREADS));

  assign idx_slot = SW'(in_i.thread_index);
  assign idx_addr = AW'(in_i.thread_index);
  assign idx_bad  = (32'(in_i.thread_index) >= 32'(THREADS));

  // Shared decrementer: a counter that was never written reads as zero.
  assign cnt_cur = cvalid_q[wptr_q] ? ram_rdata_i : '0;
  assign cnt_dec = cnt_cur - TICKS_W'(1);

  assign cur_ext  = XW'(cur_q);
  assign last_ext = XW'(last_q);

  assign ram_raddr_o = ptr_q[AW-1:0];

  // Sequencer and scheduler state.
  always_comb begin
    state_d      = state_q;
    ready_d      = ready_q;
    cvalid_d     = cvalid_q;
    cur_d        = cur_q;
    last_d       = last_q;
    sw_d         = sw_q;
    status_d     = status_q;
    ptr_d        = ptr_q;
    pend_d       = pend_q;
    wptr_d       = wptr_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_run_d    = out_run_q;
    out_prev_d   = out_prev_q;
    out_sw_d     = out_sw_q;
    ram_we_o     = 1'b0;
    ram_waddr_o  = wptr_q;
    ram_wdata_o  = cnt_dec;

    if (out_o.valid && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          status_d = STATUS_OK;
          sw_d     = 1'b0;
          ptr_d    = '0;
          pend_d   = 1'b0;
          case (mode_e'(in_i.mode))
            MODE_TICK: begin
              state_d = S_TICK;
            end
            MODE_DELAY: begin
              if (in_i.delay_ticks != '0) begin
                // The idle slot has no counter, only a ready bit.
                if (cur_q < SW'(THREADS)) begin
                  ram_we_o                 = 1'b1;
                  ram_waddr_o              = cur_q[AW-1:0];
                  ram_wdata_o              = in_i.delay_ticks;
                  cvalid_d[cur_q[AW-1:0]]  = 1'b1;
                end
                ready_d[cur_q] = 1'b0;
                state_d        = S_SCAN;
              end else begin
                state_d = S_RESP;
              end
            end
            MODE_YIELD: begin
              state_d = S_SCAN;
            end
            MODE_CREATE: begin
              if (idx_bad) begin
                status_d = STATUS_RANGE;
              end else if (ready_q[idx_slot]) begin
                status_d = STATUS_IS_READY;
              end else begin
                // A counter without its valid bit reads as zero.
                cvalid_d[idx_addr] = 1'b0;
                ready_d[idx_slot]  = 1'b1;
              end
              state_d = S_RESP;
            end
            default: begin
              state_d = S_RESP;
            end
          endcase
        end
      end

      S_TICK: begin
        // Read one counter a cycle and write back the one read before it.
        if (pend_q && (cnt_cur != '0)) begin
          ram_we_o         = 1'b1;
          cvalid_d[wptr_q] = 1'b1;
          if (cnt_dec == '0) begin
            ready_d[SW'(wptr_q)] = 1'b1;
          end
        end
        if (rd_issue) begin
          pend_d = 1'b1;
          wptr_d = ptr_q[AW-1:0];
          ptr_d  = ptr_q + SW'(1);
        end else begin
          pend_d  = 1'b0;
          ptr_d   = '0;
          state_d = S_SCAN;
        end
      end

      S_SCAN: begin
        // Look for the lowest ready slot, one slot a cycle.
        if (ready_q[ptr_q]) begin
          last_d  = cur_q;
          cur_d   = ptr_q;
          sw_d    = (ptr_q != cur_q);
          state_d = S_RESP;
        end else if (ptr_q == SW'(THREADS)) begin
          last_d  = cur_q;
          sw_d    = 1'b0;
          state_d = S_RESP;
        end else begin
          ptr_d = ptr_q + SW'(1);
        end
      end

      S_RESP: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = status_q;
          out_run_d    = cur_ext[INDEX_W-1:0];
          out_prev_d   = last_ext[INDEX_W-1:0];
          out_sw_d     = sw_q;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control and scheduler registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ready_q     <= '0;
      cvalid_q    <= '0;
      cur_q       <= '0;
      last_q      <= '0;
      sw_q        <= 1'b0;
      status_q    <= STATUS_OK;
      ptr_q       <= '0;
      pend_q      <= 1'b0;
      wptr_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ready_q     <= ready_d;
      cvalid_q    <= cvalid_d;
      cur_q       <= cur_d;
      last_q      <= last_d;
      sw_q        <= sw_d;
      status_q    <= status_d;
      ptr_q       <= ptr_d;
      pend_q      <= pend_d;
      wptr_q      <= wptr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload register.
  always_ff @(posedge clk_i) begin
    out_status_q <= out_status_d;
    out_run_q    <= out_run_d;
    out_prev_q   <= out_prev_d;
    out_sw_q     <= out_sw_d;
  end

  assign in_i.ready            = (state_q == S_IDLE);
  assign out_o.valid           = out_valid_q;
  assign out_o.status          = out_status_q;
  assign out_o.running_thread  = out_run_q;
  assign out_o.previous_thread = out_prev_q;
  assign out_o.switch_request  = out_sw_q;

endmodule

// File: src/priority_ready_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_ready_scheduler: bitmap priority scheduler with delay timers
// Keeps a ready bit and a delay counter per thread plus the running slot,
// and answers tick, delay, yield and create operations.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one operation per item (mode, thread_index, delay_ticks);
//   out_o returns exactly one result item for every accepted item.
//   in_i.ready is high only while the sequencer is idle; one item is worked
//   on at a time, and the next item may be taken while a result still waits.
// Steps from accept to result valid:
//   create, or delay with zero ticks: straight to the result state.
//   yield, or delay with nonzero ticks: a ready-bit scan that visits 1 to
//   THREADS+1 slots, then the result state.
//   tick: a counter pass, then the scan and the result state; the counters go
//   through one shared decrementer, one counter a cycle, from a counter memory
//   with one read and one write port.
//   A new item can be taken in the same cycle in which its result becomes valid.
// Reset clears all ready bits, all counters (by per-entry valid bits) and
// the running slot at once; no clearing pass is needed.
// When out_o.ready stays low, the finished result is held, and a second
// finished result waits in the sequencer, holding in_i.ready low.
// ----------------------------------------------------------------------------
module priority_ready_scheduler #(
  parameter int unsigned THREADS = prs_pkg::DEFAULT_THREADS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  prs_in_if.sink    in_i,
  prs_out_if.source out_o
);
  import prs_pkg::*;

  localparam int unsigned AW = (THREADS > 1) ? $clog2(THREADS) : 1;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [TICKS_W-1:0] ram_wdata;
  logic [AW-1:0]      ram_raddr;
  logic [TICKS_W-1:0] ram_rdata;

  // Sequencer with the shared decrementer and slot scan.
  prs_seq #(
    .THREADS (THREADS)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .out_o       (out_o),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  // Delay counter store, one entry per thread.
  prs_ram #(
    .WIDTH (TICKS_W),
    .DEPTH (THREADS)
  ) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule
